[rtl/scfr_pkg.sv]
// ----------------------------------------------------------------------------
// scfr_pkg - shared types and constants
// Field widths, register codes and the command/status bundles that join the
// receiver controller and datapath.
// ----------------------------------------------------------------------------
package scfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 6;
    localparam int MAXLEN_W  = 6;
    localparam int SUM_W     = 16;
    localparam int TOT_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0]   HEADER_RESET  = 8'd85;
    localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 6'd56;

    localparam int MIN_FRAME   = 8;
    localparam int LEN_POS     = 3;
    localparam int WORD_LO_OFS = 4;
    localparam int WORD_HI_OFS = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_BYTE  = 1'b0,
        CFG_MAX_DATA_LEN = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic store;
        logic rd_head;
        logic rd_scan;
        logic drop;
        logic hunt;
        logic collect;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic hunting;
        logic win_empty;
        logic scan_end;
        logic cand_full;
        logic col_pass;
        logic emit_last;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/scfr_channels.sv]
// ----------------------------------------------------------------------------
// scfr_channels - valid/ready channel interfaces
// Receive byte channel, validated frame channel and register write channel.
// ----------------------------------------------------------------------------
interface scfr_rx_if import scfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfr_frame_if import scfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              frame_last;

    modport source (output valid, output frame_byte, output byte_index, output frame_last,
                    input ready);
    modport sink   (input valid, input frame_byte, input byte_index, input frame_last,
                    output ready);
endinterface

interface scfr_cfg_if import scfr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/scfr_ram.sv]
// ----------------------------------------------------------------------------
// scfr_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module scfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/scfr_ctrl.sv]
// ----------------------------------------------------------------------------
// scfr_ctrl - receiver sequencer
// Stores each word, then walks the window: header hunt, collection, and
// emission of at most one validated frame per received word.
// ----------------------------------------------------------------------------
module scfr_ctrl import scfr_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_CHECK    = 6'b000010,
        ST_HUNT     = 6'b000100,
        ST_COLLECT  = 6'b001000,
        ST_EMIT_RD  = 6'b010000,
        ST_EMIT_PUT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.hunting)
                begin
                    if (stat.win_empty)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_head = 1'b1;
                        state_next  = ST_HUNT;
                    end
                end
                else if (stat.cand_full)
                begin
                    cmd.drop = 1'b1;
                end
                else if (stat.scan_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = ST_COLLECT;
                end
            end
            ST_HUNT:
            begin
                cmd.hunt   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_COLLECT:
            begin
                cmd.collect = 1'b1;
                state_next  = stat.col_pass ? ST_EMIT_RD : ST_CHECK;
            end
            ST_EMIT_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = ST_EMIT_PUT;
            end
            ST_EMIT_PUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/scfr_dp.sv]
// ----------------------------------------------------------------------------
// scfr_dp - receiver datapath
// Window RAM and pointers, candidate length and checksum, configuration
// registers and the frame output register.
// ----------------------------------------------------------------------------
module scfr_dp import scfr_pkg::*; #(
    parameter int WINDOW_DEPTH = 128,
    parameter int FRAME_MAX    = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [BYTE_W-1:0]   rx_byte,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    scfr_cfg_if.sink            cfg,
    scfr_frame_if.source        frame
);

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int CL_W  = $clog2(FRAME_MAX + 1);

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [PTR_W-1:0]    scan_reg, scan_next;
    logic [CL_W-1:0]     cl_reg, cl_next;
    logic [CL_W-1:0]     k_reg, k_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [BYTE_W-1:0]   len_reg, len_next;
    logic [BYTE_W-1:0]   word_lo_reg, word_lo_next;
    logic [BYTE_W-1:0]   word_hi_reg, word_hi_next;
    logic [BYTE_W-1:0]   header_reg;
    logic [MAXLEN_W-1:0] max_len_reg;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic [IDX_W-1:0]    out_index_reg;
    logic                out_last_reg;

    logic [BYTE_W-1:0]   rd_data;
    logic [PTR_W-1:0]    head_inc;
    logic                full;
    logic                wr_en;
    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr;
    logic [CL_W-1:0]     cl_inc;
    logic [TOT_W-1:0]    idx_ext;
    logic [TOT_W-1:0]    len_ext;
    logic [TOT_W-1:0]    total;
    logic [TOT_W-1:0]    cl_inc_ext;
    logic                covered;
    logic                len_over;
    logic                at_min;
    logic                at_total;
    logic                sum_ok;
    logic                col_fail;
    logic                col_pass;
    logic                hdr_match;
    logic                emit_last;
    logic                out_free;
    logic                drop_any;

    assign head_inc  = wrap_inc(head_reg);
    assign full      = (wrap_inc(tail_reg) == head_reg);
    assign wr_en     = cmd.store && !full;
    assign rd_en     = cmd.rd_head || cmd.rd_scan;
    assign rd_addr   = cmd.rd_scan ? scan_reg : head_reg;

    scfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cl_inc     = cl_reg + 1'b1;
    assign idx_ext    = TOT_W'(cl_reg);
    assign len_ext    = TOT_W'(len_reg);
    assign total      = len_ext + TOT_W'(MIN_FRAME);
    assign cl_inc_ext = TOT_W'(cl_inc);
    assign covered    = (idx_ext <= TOT_W'(LEN_POS)) || (idx_ext <= len_ext + TOT_W'(LEN_POS));
    assign len_over   = len_reg > BYTE_W'(max_len_reg);
    assign at_min     = cl_inc_ext >= TOT_W'(MIN_FRAME);
    assign at_total   = cl_inc_ext == total;
    assign sum_ok     = {word_hi_reg, word_lo_reg} == sum_reg;
    assign col_fail   = at_min && (len_over || (at_total && !sum_ok));
    assign col_pass   = at_min && !len_over && at_total && sum_ok;
    assign hdr_match  = rd_data == header_reg;
    assign emit_last  = (TOT_W'(k_reg) + 1'b1) == total;
    assign out_free   = !out_valid_reg || frame.ready;
    assign drop_any   = cmd.drop || (cmd.hunt && !hdr_match) || (cmd.collect && col_fail);

    always_comb
    begin
        stat.hunting   = (cl_reg == '0);
        stat.win_empty = (head_reg == tail_reg);
        stat.scan_end  = (scan_reg == tail_reg);
        stat.cand_full = (cl_reg >= CL_W'(FRAME_MAX));
        stat.col_pass  = col_pass;
        stat.emit_last = emit_last;
        stat.out_free  = out_free;
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        scan_next      = scan_reg;
        cl_next        = cl_reg;
        k_next         = k_reg;
        sum_next       = sum_reg;
        len_next       = len_reg;
        word_lo_next   = word_lo_reg;
        word_hi_next   = word_hi_reg;
        out_valid_next = out_valid_reg && !frame.ready;

        if (wr_en)
        begin
            tail_next = wrap_inc(tail_reg);
        end

        if (drop_any)
        begin
            head_next = head_inc;
            scan_next = head_inc;
            cl_next   = '0;
            sum_next  = '0;
        end
        else if (cmd.hunt)
        begin
            cl_next   = CL_W'(1);
            sum_next  = '0;
            scan_next = head_inc;
        end
        else if (cmd.collect)
        begin
            scan_next = wrap_inc(scan_reg);
            cl_next   = cl_inc;
            if (covered)
            begin
                sum_next = sum_reg + SUM_W'(rd_data);
            end
            if (idx_ext == TOT_W'(LEN_POS))
            begin
                len_next = rd_data;
            end
            if (idx_ext == len_ext + TOT_W'(WORD_LO_OFS))
            begin
                word_lo_next = rd_data;
            end
            if (idx_ext == len_ext + TOT_W'(WORD_HI_OFS))
            begin
                word_hi_next = rd_data;
            end
            if (col_pass)
            begin
                k_next = '0;
            end
        end
        else if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            head_next      = head_inc;
            k_next         = k_reg + 1'b1;
            if (emit_last)
            begin
                scan_next = head_inc;
                cl_next   = '0;
                sum_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            scan_reg      <= '0;
            cl_reg        <= '0;
            k_reg         <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            header_reg    <= HEADER_RESET;
            max_len_reg   <= MAX_LEN_RESET;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            scan_reg      <= scan_next;
            cl_reg        <= cl_next;
            k_reg         <= k_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_HEADER_BYTE:  header_reg  <= cfg.data;
                    CFG_MAX_DATA_LEN: max_len_reg <= cfg.data[MAXLEN_W-1:0];
                    default:          header_reg  <= header_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        word_lo_reg <= word_lo_next;
        word_hi_reg <= word_hi_next;
        if (cmd.emit)
        begin
            out_byte_reg  <= rd_data;
            out_index_reg <= IDX_W'(k_reg);
            out_last_reg  <= emit_last;
        end
    end

    assign cfg.ready        = 1'b1;
    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.byte_index = out_index_reg;
    assign frame.frame_last = out_last_reg;

`ifndef SYNTHESIS
    a_cl_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cl_reg <= CL_W'(FRAME_MAX))
        else $error("candidate length beyond frame maximum");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("frame word loaded over a pending word");

    a_collect_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.collect |-> $past(cmd.rd_scan))
        else $error("collect without a scan read");

    a_frame_done_rescan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && emit_last |=> (cl_reg == '0) && (scan_reg == head_reg))
        else $error("state not returned to hunting after frame");
`endif

endmodule

[rtl/sum_checked_frame_receiver_core.sv]
// ----------------------------------------------------------------------------
// sum_checked_frame_receiver_core - framed byte receiver with sum check
// Buffers received words in a circular window, hunts for the header word,
// checks the length field and 16-bit additive checksum, and emits each good
// frame word by word.
// ----------------------------------------------------------------------------
// A received word is taken only while the receiver is idle and is written to
// the window (dropped when the window holds WINDOW_DEPTH-1 words). The window
// is then walked through its single RAM read port: every buffered word examined
// takes a decide step and a read step, and a failed candidate returns to the
// word after its header. A good frame goes out word by word, a window read
// before each output load, and waits while the output is not taken; at most one
// frame leaves per received word, and any rest of the window is examined after
// the next word. No clearing pass follows reset. Register writes are taken at
// any time.
module sum_checked_frame_receiver_core import scfr_pkg::*; #(
    parameter int WINDOW_DEPTH = 128,
    parameter int FRAME_MAX    = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    scfr_rx_if.sink       rx,
    scfr_frame_if.source  frame,
    scfr_cfg_if.sink      cfg
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    scfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scfr_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .FRAME_MAX    (FRAME_MAX)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (rx.rx_byte),
        .cmd     (cmd),
        .stat    (stat),
        .cfg     (cfg),
        .frame   (frame)
    );

endmodule

[tb/sum_checked_frame_receiver_core_tb.sv]
// ----------------------------------------------------------------------------
// sum_checked_frame_receiver_core_tb - self-checking bench for the frame receiver
// Feeds received words through a random-stalling driver, mirrors the window,
// header hunt, length limit and sum check in a local model of the receiver,
// and compares every validated frame word against that model.
// ----------------------------------------------------------------------------
module sum_checked_frame_receiver_core_tb import scfr_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_DEPTH  = 128;
    localparam int FRAME_CAP  = 64;
    localparam int SETTLE     = 2 * FRAME_CAP * WIN_DEPTH;
    localparam int TAIL_WORDS = 60;

    typedef enum logic [1:0] {
        ACT_WORD,
        ACT_CFG,
        ACT_HOLD
    } stim_kind_t;

    typedef struct {
        stim_kind_t        kind;
        logic [BYTE_W-1:0] data;
        cfg_reg_t          addr;
        int                settle;
    } stim_act_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [IDX_W-1:0]  byte_index;
        logic              frame_last;
    } frame_word_t;

    logic clk;
    logic rst_n;

    scfr_rx_if    rx_ch();
    scfr_frame_if frame_ch();
    scfr_cfg_if   cfg_ch();

    sum_checked_frame_receiver_core #(
        .WINDOW_DEPTH (WIN_DEPTH),
        .FRAME_MAX    (FRAME_CAP)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frame (frame_ch),
        .cfg   (cfg_ch)
    );

    // receiver model state
    logic [BYTE_W-1:0]   win_mem [0:WIN_DEPTH-1];
    int unsigned         win_head;
    int unsigned         win_tail;
    int unsigned         scan_pos;
    int unsigned         cand_len;
    logic [SUM_W-1:0]    run_sum;
    logic [BYTE_W-1:0]   hdr_val;
    logic [MAXLEN_W-1:0] max_len;

    frame_word_t frame_exp_q[$];
    stim_act_t   pending_q[$];
    logic [BYTE_W-1:0] frame_buf[$];

    logic [BYTE_W-1:0] plan_hdr;
    int                plan_max;
    int                planned_words;

    int words_taken;
    int frames_expected;
    int frame_words_checked;
    int cfg_writes;
    int err_cnt;

    // driver scratch
    bit                   rx_busy;
    bit                   cfg_busy;
    bit                   nxt_rx_valid;
    bit                   nxt_cfg_valid;
    logic [BYTE_W-1:0]    nxt_byte;
    logic [CFG_IDX_W-1:0] nxt_cfg_idx;
    logic [BYTE_W-1:0]    nxt_cfg_data;
    int                   gap_left;
    int                   hold_cnt;
    stim_act_t            act;

    // monitor scratch
    int          stall_left;
    frame_word_t want;

    function automatic int unsigned win_at(input int unsigned ofs);
        return win_mem[(win_head + ofs) % WIN_DEPTH];
    endfunction

    function automatic void skip_lead_byte();
        win_head = (win_head + 1) % WIN_DEPTH;
        scan_pos = win_head;
        cand_len = 0;
        run_sum  = '0;
    endfunction

    function automatic void frame_predict(input logic [BYTE_W-1:0] b);
        int unsigned       idx;
        int unsigned       len;
        int unsigned       total;
        logic [BYTE_W-1:0] v;
        logic [SUM_W-1:0]  sum_word;
        frame_word_t       fw;
        bit                running;
        running = 1'b1;
        if ((win_tail + 1) % WIN_DEPTH != win_head)
        begin
            win_mem[win_tail] = b;
            win_tail = (win_tail + 1) % WIN_DEPTH;
        end
        while (running)
        begin
            if (cand_len == 0)
            begin
                if (win_head == win_tail)
                    running = 1'b0;
                else if (win_at(0) != hdr_val)
                    skip_lead_byte();
                else
                begin
                    cand_len = 1;
                    run_sum  = '0;
                    scan_pos = (win_head + 1) % WIN_DEPTH;
                end
            end
            else if (cand_len >= FRAME_CAP)
                skip_lead_byte();
            else if (scan_pos == win_tail)
                running = 1'b0;
            else
            begin
                idx      = cand_len;
                v        = win_mem[scan_pos];
                scan_pos = (scan_pos + 1) % WIN_DEPTH;
                cand_len = idx + 1;
                if (idx >= 1 && (idx <= LEN_POS || idx <= win_at(LEN_POS) + LEN_POS))
                    run_sum = run_sum + v;
                if (cand_len >= MIN_FRAME)
                begin
                    len = win_at(LEN_POS);
                    if (len > max_len)
                        skip_lead_byte();
                    else
                    begin
                        total = len + MIN_FRAME;
                        if (cand_len >= total)
                        begin
                            sum_word = {BYTE_W'(win_at(total - 3)), BYTE_W'(win_at(total - 4))};
                            if (sum_word != run_sum)
                                skip_lead_byte();
                            else
                            begin
                                for (int unsigned k = 0; k < total; k++)
                                begin
                                    fw.frame_byte = BYTE_W'(win_at(k));
                                    fw.byte_index = IDX_W'(k);
                                    fw.frame_last = (k + 1 == total);
                                    frame_exp_q.push_back(fw);
                                end
                                frames_expected++;
                                win_head = (win_head + total) % WIN_DEPTH;
                                scan_pos = win_head;
                                cand_len = 0;
                                run_sum  = '0;
                                running  = 1'b0;
                            end
                        end
                    end
                end
            end
        end
    endfunction

    function automatic void report_miss(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic bit in_tail();
        return pending_q.size() < TAIL_WORDS;
    endfunction

    function automatic void push_word(input logic [BYTE_W-1:0] b);
        pending_q.push_back('{kind: ACT_WORD, data: b, addr: CFG_HEADER_BYTE, settle: 0});
        planned_words++;
    endfunction

    function automatic void push_cfg(input cfg_reg_t addr, input logic [BYTE_W-1:0] d);
        pending_q.push_back('{kind: ACT_CFG, data: d, addr: addr, settle: 0});
    endfunction

    function automatic void push_hold(input int settle);
        pending_q.push_back('{kind: ACT_HOLD, data: '0, addr: CFG_HEADER_BYTE, settle: settle});
    endfunction

    // header, two free bytes, length, payload
    function automatic void make_frame(input logic [BYTE_W-1:0] hdr, input int len);
        frame_buf.delete();
        frame_buf.push_back(hdr);
        frame_buf.push_back(BYTE_W'($urandom));
        frame_buf.push_back(BYTE_W'($urandom));
        frame_buf.push_back(BYTE_W'(len));
        for (int i = 0; i < len; i++)
            frame_buf.push_back(BYTE_W'($urandom));
    endfunction

    // append sum word and trailer
    function automatic void seal_frame(input bit bad_sum);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int i = 1; i < frame_buf.size(); i++)
            s = s + frame_buf[i];
        if (bad_sum)
            s = s + SUM_W'($urandom_range(1, 65535));
        frame_buf.push_back(s[7:0]);
        frame_buf.push_back(s[15:8]);
        frame_buf.push_back(BYTE_W'($urandom));
        frame_buf.push_back(BYTE_W'($urandom));
    endfunction

    function automatic void push_buf(input int count);
        for (int i = 0; i < count && i < frame_buf.size(); i++)
            push_word(frame_buf[i]);
    endfunction

    function automatic void push_mix(input int quota);
        int target;
        int pick;
        int cap;
        int len;
        target = planned_words + quota;
        cap = (plan_max > FRAME_CAP - MIN_FRAME) ? FRAME_CAP - MIN_FRAME : plan_max;
        while (planned_words < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(0, cap);
                else
                    len = $urandom_range(0, (cap < 6) ? cap : 6);
                make_frame(plan_hdr, len);
                seal_frame(pick >= 11);
                push_buf(frame_buf.size());
            end
            else if (pick < 16)
            begin
                if (plan_max > FRAME_CAP - MIN_FRAME && $urandom_range(0, 1) == 0)
                begin
                    make_frame(plan_hdr, $urandom_range(FRAME_CAP - MIN_FRAME + 1, plan_max));
                    seal_frame(1'b0);
                    push_buf(frame_buf.size());
                end
                else
                begin
                    len = (plan_max >= 63) ? $urandom_range(64, 255)
                                           : $urandom_range(plan_max + 1, 255);
                    make_frame(plan_hdr, len);
                    push_buf(MIN_FRAME + $urandom_range(0, 4));
                end
            end
            else if (pick < 18)
            begin
                repeat ($urandom_range(1, 4))
                    push_word(($urandom_range(0, 7) == 0) ? plan_hdr : BYTE_W'($urandom));
            end
            else
            begin
                make_frame(plan_hdr, $urandom_range(0, (cap < 6) ? cap : 6));
                seal_frame(1'b0);
                push_buf($urandom_range(1, frame_buf.size() - 1));
            end
        end
    endfunction

    function automatic void set_plan(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] mdl);
        push_hold(SETTLE);
        push_cfg(CFG_HEADER_BYTE, hdr);
        push_cfg(CFG_MAX_DATA_LEN, mdl);
        plan_hdr = hdr;
        plan_max = mdl[MAXLEN_W-1:0];
    endfunction

    function automatic void push_nested();
        logic [BYTE_W-1:0] inner[$];
        make_frame(plan_hdr, $urandom_range(0, 2));
        seal_frame(1'b0);
        inner = frame_buf;
        make_frame(plan_hdr, inner.size());
        for (int i = 0; i < inner.size(); i++)
            frame_buf[4 + i] = inner[i];
        seal_frame(1'b1);
        push_buf(frame_buf.size());
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL sum_checked_frame_receiver_core");
        $finish;
    end

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
            cfg_ch.valid  <= 1'b0;
            cfg_ch.index  <= CFG_HEADER_BYTE;
            cfg_ch.data   <= '0;
        end
        else
        begin
            rx_busy  = rx_ch.valid;
            cfg_busy = cfg_ch.valid;
            if (rx_ch.valid && rx_ch.ready)
            begin
                frame_predict(rx_ch.rx_byte);
                words_taken++;
                rx_busy = 1'b0;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == CFG_HEADER_BYTE)
                    hdr_val = cfg_ch.data;
                else
                    max_len = cfg_ch.data[MAXLEN_W-1:0];
                cfg_writes++;
                cfg_busy = 1'b0;
            end
            nxt_rx_valid  = rx_busy;
            nxt_cfg_valid = cfg_busy;
            nxt_byte      = rx_ch.rx_byte;
            nxt_cfg_idx   = cfg_ch.index;
            nxt_cfg_data  = cfg_ch.data;
            if (!rx_busy && !cfg_busy)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() > 0)
                begin
                    act = pending_q[0];
                    case (act.kind)
                        ACT_WORD:
                        begin
                            nxt_rx_valid = 1'b1;
                            nxt_byte     = act.data;
                            void'(pending_q.pop_front());
                            if (!in_tail() && $urandom_range(0, 3) == 0)
                                gap_left = $urandom_range(1, 10);
                        end
                        ACT_CFG:
                        begin
                            nxt_cfg_valid = 1'b1;
                            nxt_cfg_idx   = act.addr;
                            nxt_cfg_data  = act.data;
                            void'(pending_q.pop_front());
                        end
                        ACT_HOLD:
                        begin
                            if (frame_exp_q.size() != 0)
                                hold_cnt = 0;
                            else if (hold_cnt >= act.settle)
                            begin
                                hold_cnt = 0;
                                void'(pending_q.pop_front());
                            end
                            else
                                hold_cnt++;
                        end
                        default:
                        begin
                            void'(pending_q.pop_front());
                        end
                    endcase
                end
            end
            rx_ch.valid   <= nxt_rx_valid;
            rx_ch.rx_byte <= nxt_byte;
            cfg_ch.valid  <= nxt_cfg_valid;
            cfg_ch.index  <= nxt_cfg_idx;
            cfg_ch.data   <= nxt_cfg_data;
        end
    end

    // frame word receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                if (frame_exp_q.size() == 0)
                    report_miss($sformatf("unexpected word byte=%02h index=%0d last=%0b",
                        frame_ch.frame_byte, frame_ch.byte_index, frame_ch.frame_last));
                else
                begin
                    want = frame_exp_q.pop_front();
                    if (want.frame_byte !== frame_ch.frame_byte ||
                        want.byte_index !== frame_ch.byte_index ||
                        want.frame_last !== frame_ch.frame_last)
                        report_miss($sformatf(
                            {"word %0d: expected byte=%02h index=%0d last=%0b, ",
                             "got byte=%02h index=%0d last=%0b"},
                            frame_words_checked, want.frame_byte, want.byte_index,
                            want.frame_last, frame_ch.frame_byte, frame_ch.byte_index,
                            frame_ch.frame_last));
                    frame_words_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                frame_ch.ready <= 1'b0;
            end
            else if (!in_tail() && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                frame_ch.ready <= 1'b0;
            end
            else
                frame_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_HEADER_BYTE;
        cfg_ch.data    = '0;
        frame_ch.ready = 1'b0;

        win_head = 0;
        win_tail = 0;
        scan_pos = 0;
        cand_len = 0;
        run_sum  = '0;
        hdr_val  = HEADER_RESET;
        max_len  = MAX_LEN_RESET;
        gap_left = 0;
        hold_cnt = 0;
        words_taken = 0;
        frames_expected = 0;
        frame_words_checked = 0;
        cfg_writes = 0;
        err_cnt = 0;
        planned_words = 0;
        plan_hdr = HEADER_RESET;
        plan_max = MAX_LEN_RESET;

        // directed: reset settings
        push_word(8'h00);
        push_word(8'hFF);
        push_word(8'hA5);
        make_frame(plan_hdr, 0);
        seal_frame(1'b0);
        push_buf(frame_buf.size());
        make_frame(plan_hdr, 2);
        seal_frame(1'b1);
        push_buf(frame_buf.size());
        make_frame(plan_hdr, 3);
        seal_frame(1'b0);
        push_buf(frame_buf.size());
        make_frame(plan_hdr, 255);
        push_buf(MIN_FRAME);
        push_nested();
        make_frame(plan_hdr, FRAME_CAP - MIN_FRAME);
        seal_frame(1'b0);
        push_buf(frame_buf.size());
        push_hold(0);

        push_mix(30);
        set_plan(8'h00, 8'd0);
        push_mix(15);
        set_plan(8'hFF, 8'd63);
        push_mix(30);
        set_plan(BYTE_W'($urandom_range(1, 254)), 8'hD4);
        push_mix(15);
        set_plan(HEADER_RESET, BYTE_W'(MAX_LEN_RESET));
        push_mix(10);
        push_hold(0);
        push_mix(10);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || rx_ch.valid || cfg_ch.valid)
            @(posedge clk);
        while (frame_exp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        err_cnt += frame_exp_q.size();

        $display("Run covered %0d received words and %0d register writes over five settings,",
                 words_taken, cfg_writes);
        $display("with %0d good frames (%0d frame words) checked and %0d errors.",
                 frames_expected, frame_words_checked, err_cnt);
        if (err_cnt == 0)
            $display("PASS sum_checked_frame_receiver_core");
        else
            $display("FAIL sum_checked_frame_receiver_core");
        $finish;
    end

endmodule
